// ===== rtl/cpb_pkg.sv =====
// Shared constants and types of the color palette builder.
// Used by cpb_cell and color_palette_builder; depends on nothing else.
package cpb_pkg;

  // Table depth and the widths that follow from it
  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);

  // Fixed field widths of the ports
  localparam int RGB_W  = 24;
  localparam int COMP_W = 8;
  localparam int PIDX_W = 8;
  localparam int COUNT_W = 9;
  localparam int MAXC_W = 9;

  // Width wide enough to compare count, capacity and depth
  localparam int CAP_W = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;

  localparam logic [MAXC_W-1:0] MAX_COLORS_RESET = 9'd184;

  // Search token that walks down the cell chain
  typedef struct packed {
    logic             active;
    logic [RGB_W-1:0] rgb;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
  } tok_t;

  // Broadcast write of one table entry
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [RGB_W-1:0] data;
  } wr_t;

  // One result beat
  typedef struct packed {
    logic [PIDX_W-1:0]  palette_index;
    logic               is_new;
    logic               is_transparent;
    logic               overflow_error;
    logic [COUNT_W-1:0] color_count;
    logic               has_transparent;
    logic               image_done;
  } res_t;

endpackage

// ===== rtl/cpb_cell.sv =====
// One cell of the palette chain: holds one table entry and compares the
// passing search token against it. Depends on cpb_pkg.
module cpb_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [cpb_pkg::IDX_W-1:0] cell_idx,
  input  logic [cpb_pkg::CNT_W-1:0] count,
  input  cpb_pkg::wr_t             wr,
  input  cpb_pkg::tok_t            tok_in,
  output cpb_pkg::tok_t            tok_out
);
  import cpb_pkg::*;

  logic [RGB_W-1:0] entry_r;
  tok_t             tok_r;
  logic             occupied;

  // Store the entry when the broadcast write addresses this cell
  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == cell_idx)) begin
      entry_r <= wr.data;
    end
  end

  // Advance the token one cell per cycle
  always_ff @(posedge clk) begin
    tok_r <= tok_in;
    if (!rst_n) begin
      tok_r.active <= 1'b0;
    end
  end

  // Only entries below the fill count take part in the match
  assign occupied = CNT_W'(cell_idx) < count;

  // Mark the first hit and pass the token on
  always_comb begin
    tok_out = tok_r;
    if (tok_r.active && !tok_r.hit && occupied && (entry_r == tok_r.rgb)) begin
      tok_out.hit     = 1'b1;
      tok_out.hit_idx = cell_idx;
    end
  end

endmodule

// ===== rtl/color_palette_builder.sv =====
// Top level of the color palette builder: control, count and flags, the
// chain of cpb_cell entries and the result register. Depends on cpb_pkg.
//
//   port group  direction  handshake        beat
//   in_*        in         in_valid/stall   one RGBA pixel with start and last
//   out_*       out        out_valid/stall  one result per pixel
//   cfg_*       in         cfg_valid/ready  max_colors write
//
// An opaque pixel sends its search token down the whole cell chain, one
// cell per cycle; then the miss or hit is resolved and the result moves
// to the output register. A transparent pixel, or any pixel while in
// error, skips the search: it is resolved at once, then moves to output.
// Reset (rst_n low, synchronous) clears count, flags and control; table
// entries hold garbage until written. A stalled result waits in the output
// register while the next pixel is already accepted and searched.
module color_palette_builder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_start_of_image,
  input  logic [cpb_pkg::COMP_W-1:0]   in_red,
  input  logic [cpb_pkg::COMP_W-1:0]   in_green,
  input  logic [cpb_pkg::COMP_W-1:0]   in_blue,
  input  logic [cpb_pkg::COMP_W-1:0]   in_alpha,
  input  logic                         in_last_pixel,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cpb_pkg::PIDX_W-1:0]   out_palette_index,
  output logic                         out_is_new,
  output logic                         out_is_transparent,
  output logic                         out_overflow_error,
  output logic [cpb_pkg::COUNT_W-1:0]  out_color_count,
  output logic                         out_has_transparent,
  output logic                         out_image_done,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cpb_pkg::MAXC_W-1:0]   cfg_max_colors
);
  import cpb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_DONE   = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ts_r, ts_nxt;
  logic              err_r, err_nxt;
  logic              last_r, last_nxt;
  logic [MAXC_W-1:0] max_colors_r;
  res_t              res_r, res_nxt;
  res_t              out_r;
  logic              out_valid_r;

  logic              in_accept;
  logic              out_load;
  logic              transp;
  logic [CNT_W-1:0]  count_eff;
  logic              ts_eff;
  logic              err_eff;
  logic [CAP_W-1:0]  cap;
  wr_t               wr;
  tok_t              tok [PALETTE_DEPTH+1];

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // State as seen by the new pixel, after an optional image start
  assign count_eff = in_start_of_image ? '0 : count_r;
  assign ts_eff    = in_start_of_image ? 1'b0 : ts_r;
  assign err_eff   = in_start_of_image ? 1'b0 : err_r;
  assign transp    = (in_alpha == '0);

  // Effective capacity saturates at the table depth
  assign cap = (CAP_W'(max_colors_r) > CAP_W'(PALETTE_DEPTH)) ?
               CAP_W'(PALETTE_DEPTH) : CAP_W'(max_colors_r);

  // Inject a search token for an opaque pixel outside error
  always_comb begin
    tok[0].active  = in_accept && !err_eff && !transp;
    tok[0].rgb     = {in_red, in_green, in_blue};
    tok[0].hit     = 1'b0;
    tok[0].hit_idx = '0;
  end

  // Chain of table cells
  for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
    cpb_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .count    (count_r),
      .wr       (wr),
      .tok_in   (tok[g]),
      .tok_out  (tok[g+1])
    );
  end

  // Sequence one pixel: accept, search, resolve, hand to output
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ts_nxt    = ts_r;
    err_nxt   = err_r;
    last_nxt  = last_r;
    res_nxt   = res_r;
    wr.en     = 1'b0;
    wr.idx    = count_r[IDX_W-1:0];
    wr.data   = tok[PALETTE_DEPTH].rgb;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          count_nxt = count_eff;
          ts_nxt    = ts_eff;
          err_nxt   = err_eff;
          last_nxt  = in_last_pixel;
          res_nxt.palette_index   = '0;
          res_nxt.is_new          = 1'b0;
          res_nxt.is_transparent  = transp;
          res_nxt.overflow_error  = err_eff;
          res_nxt.color_count     = COUNT_W'(count_eff);
          res_nxt.has_transparent = ts_eff;
          res_nxt.image_done      = in_last_pixel;
          priority if (err_eff) begin
            state_nxt = S_DONE;
          end else if (transp) begin
            ts_nxt                  = 1'b1;
            res_nxt.has_transparent = 1'b1;
            state_nxt               = S_DONE;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (tok[PALETTE_DEPTH].active) begin
          res_nxt.palette_index   = '0;
          res_nxt.is_new          = 1'b0;
          res_nxt.is_transparent  = 1'b0;
          res_nxt.overflow_error  = 1'b0;
          res_nxt.color_count     = COUNT_W'(count_r);
          res_nxt.has_transparent = ts_r;
          res_nxt.image_done      = last_r;
          priority if (tok[PALETTE_DEPTH].hit) begin
            res_nxt.palette_index = PIDX_W'(tok[PALETTE_DEPTH].hit_idx);
          end else if (CAP_W'(count_r) >= cap) begin
            err_nxt                = 1'b1;
            res_nxt.overflow_error = 1'b1;
          end else begin
            wr.en                 = 1'b1;
            count_nxt             = count_r + CNT_W'(1);
            res_nxt.palette_index = PIDX_W'(count_r);
            res_nxt.is_new        = 1'b1;
            res_nxt.color_count   = COUNT_W'(count_nxt);
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      ts_r         <= 1'b0;
      err_r        <= 1'b0;
      max_colors_r <= MAX_COLORS_RESET;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ts_r    <= ts_nxt;
      err_r   <= err_nxt;
      if (cfg_valid && cfg_ready) begin
        max_colors_r <= cfg_max_colors;
      end
    end
  end

  // Payload of the pixel in flight
  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    res_r  <= res_nxt;
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= res_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_palette_index   = out_r.palette_index;
  assign out_is_new          = out_r.is_new;
  assign out_is_transparent  = out_r.is_transparent;
  assign out_overflow_error  = out_r.overflow_error;
  assign out_color_count     = out_r.color_count;
  assign out_has_transparent = out_r.has_transparent;
  assign out_image_done      = out_r.image_done;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CAP_W'(count_r) <= CAP_W'(PALETTE_DEPTH))
    else $error("palette count beyond table depth");

  a_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == S_SEARCH) && !tok[PALETTE_DEPTH].hit)
    else $error("table write outside a missed search");

  a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tok[PALETTE_DEPTH].active |-> (state_r == S_SEARCH))
    else $error("search token left the chain outside a search");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat appeared without a resolved pixel");

  a_err_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r && !(in_accept && in_start_of_image)) |=> $stable(count_r))
    else $error("palette count moved while in overflow");
`endif

endmodule
